// ===== hdl/teig_pkg.sv =====
// Package with the shared types and constants of the trap entry and interrupt gate.
package teig_pkg;

   // Item kinds carried on the request channel.
   typedef enum logic [1:0] {
      ACT_RAISE   = 2'd0,
      ACT_QUERY   = 2'd1,
      ACT_POST    = 2'd2,
      ACT_RESTORE = 2'd3
   } action_type;

   // Interrupt kinds reported by a query.
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_TIMER = 2'd1,
      KIND_UART  = 2'd2
   } irq_kind_type;

   // Privilege level codes.
   localparam logic [1:0] LEVEL_USER     = 2'd0;
   localparam logic [1:0] LEVEL_SUPER    = 2'd1;
   localparam logic [1:0] LEVEL_RESERVED = 2'd2;
   localparam logic [1:0] LEVEL_MACHINE  = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MACHINE_VECTOR    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUPERVISOR_VECTOR = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELEGATION_MASK   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MACHINE_IRQ_EN    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUPERVISOR_IRQ_EN = 3'd4;

   // Status word bit positions.
   localparam int unsigned MIE_BIT  = 3;
   localparam int unsigned MPIE_BIT = 7;
   localparam int unsigned MPP_LSB  = 11;
   localparam int unsigned SIE_BIT  = 1;
   localparam int unsigned SPIE_BIT = 5;
   localparam int unsigned SPP_LSB  = 8;

   localparam int unsigned XLEN = 32;

   // One request beat as held in the input register.
   typedef struct packed {
      action_type       action;
      logic [XLEN-1:0]  cause;
      logic [XLEN-1:0]  trap_pc;
      logic             uart_ready;
      logic [XLEN-1:0]  new_mstatus;
      logic [XLEN-1:0]  new_sstatus;
      logic [1:0]       new_level;
   } req_type;

   // One response beat as held in the result register.
   typedef struct packed {
      logic [XLEN-1:0]  target_pc;
      irq_kind_type     irq_kind;
      logic             bad_level;
      logic [XLEN-1:0]  mstatus;
      logic [XLEN-1:0]  sstatus;
      logic [XLEN-1:0]  mepc;
      logic [XLEN-1:0]  sepc;
      logic [XLEN-1:0]  mcause;
      logic [XLEN-1:0]  scause;
      logic [1:0]       level;
   } rsp_type;

endpackage

// ===== hdl/trap_entry_and_interrupt_gate_unit.sv =====
// Trap entry and interrupt gate: request register, single-pass trap logic and result register.

// Each request beat is one of four actions (raise trap, query interrupt, post interrupt
// request, restore state) and yields exactly one response beat carrying the handler vector,
// the interrupt answer, the reserved-level flag and the status, epc, cause and level state
// after the action. A beat is captured in the request register, processed by one level of
// shallow bit logic that updates the architectural trap state, and lands in the response
// register; a new beat is taken every cycle while the response side keeps up, and only a
// stalled response register holds the pipe. The configuration port is always ready and
// must be written only while the unit is idle.
module trap_entry_and_interrupt_gate_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [teig_pkg::XLEN-1:0]             req_cause,
   input  logic [teig_pkg::XLEN-1:0]             req_trap_pc,
   input  logic                                  req_uart_ready,
   input  logic [teig_pkg::XLEN-1:0]             req_new_mstatus,
   input  logic [teig_pkg::XLEN-1:0]             req_new_sstatus,
   input  logic [1:0]                            req_new_level,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [teig_pkg::XLEN-1:0]             rsp_target_pc,
   output logic [1:0]                            rsp_irq_kind,
   output logic                                  rsp_bad_level,
   output logic [teig_pkg::XLEN-1:0]             rsp_out_mstatus,
   output logic [teig_pkg::XLEN-1:0]             rsp_out_sstatus,
   output logic [teig_pkg::XLEN-1:0]             rsp_out_mepc,
   output logic [teig_pkg::XLEN-1:0]             rsp_out_sepc,
   output logic [teig_pkg::XLEN-1:0]             rsp_out_mcause,
   output logic [teig_pkg::XLEN-1:0]             rsp_out_scause,
   output logic [1:0]                            rsp_out_level,
   // configuration port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [teig_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [teig_pkg::XLEN-1:0]             csr_data
);

   // configuration registers
   logic [teig_pkg::XLEN-1:0] machine_vector_ff;
   logic [teig_pkg::XLEN-1:0] supervisor_vector_ff;
   logic [teig_pkg::XLEN-1:0] delegation_mask_ff;
   logic                      machine_irq_en_ff;
   logic                      supervisor_irq_en_ff;

   // architectural trap state
   logic [teig_pkg::XLEN-1:0] mstatus_ff, mstatus_in;
   logic [teig_pkg::XLEN-1:0] sstatus_ff, sstatus_in;
   logic [teig_pkg::XLEN-1:0] mepc_ff, mepc_in;
   logic [teig_pkg::XLEN-1:0] sepc_ff, sepc_in;
   logic [teig_pkg::XLEN-1:0] mcause_ff, mcause_in;
   logic [teig_pkg::XLEN-1:0] scause_ff, scause_in;
   logic [1:0]                level_ff, level_in;
   logic                      pending_ff, pending_in;

   // pipeline registers
   logic                 req_held_ff;
   teig_pkg::req_type    req_data_ff;
   logic                 rsp_valid_ff;
   teig_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                 advance;
   logic                 delegate;
   logic                 to_super;
   logic                 to_machine;
   logic                 low_level;

   assign csr_ready = 1'b1;
   assign advance   = req_held_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_held_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         machine_vector_ff    <= '0;
         supervisor_vector_ff <= '0;
         delegation_mask_ff   <= '0;
         machine_irq_en_ff    <= 1'b0;
         supervisor_irq_en_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            teig_pkg::CSR_MACHINE_VECTOR:    machine_vector_ff    <= csr_data;
            teig_pkg::CSR_SUPERVISOR_VECTOR: supervisor_vector_ff <= csr_data;
            teig_pkg::CSR_DELEGATION_MASK:   delegation_mask_ff   <= csr_data;
            teig_pkg::CSR_MACHINE_IRQ_EN:    machine_irq_en_ff    <= csr_data[0];
            teig_pkg::CSR_SUPERVISOR_IRQ_EN: supervisor_irq_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_held_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         req_held_ff <= 1'b1;
      end else if (advance) begin
         req_held_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff.action      <= teig_pkg::action_type'(req_action);
         req_data_ff.cause       <= req_cause;
         req_data_ff.trap_pc     <= req_trap_pc;
         req_data_ff.uart_ready  <= req_uart_ready;
         req_data_ff.new_mstatus <= req_new_mstatus;
         req_data_ff.new_sstatus <= req_new_sstatus;
         req_data_ff.new_level   <= req_new_level;
      end
   end

   // Causes of 32 and above have no mask bit and are never delegated from machine mode.
   assign delegate  = (req_data_ff.cause[teig_pkg::XLEN-1:5] == '0) &&
                      delegation_mask_ff[req_data_ff.cause[4:0]];
   assign low_level = (level_ff == teig_pkg::LEVEL_USER) ||
                      (level_ff == teig_pkg::LEVEL_SUPER);
   assign to_super   = low_level || ((level_ff == teig_pkg::LEVEL_MACHINE) && delegate);
   assign to_machine = (level_ff == teig_pkg::LEVEL_MACHINE) && !delegate;

   always_comb begin
      mstatus_in = mstatus_ff;
      sstatus_in = sstatus_ff;
      mepc_in    = mepc_ff;
      sepc_in    = sepc_ff;
      mcause_in  = mcause_ff;
      scause_in  = scause_ff;
      level_in   = level_ff;
      pending_in = pending_ff;
      rsp_data_in.target_pc = '0;
      rsp_data_in.irq_kind  = teig_pkg::KIND_NONE;
      rsp_data_in.bad_level = 1'b0;

      case (req_data_ff.action)
         teig_pkg::ACT_RAISE: begin
            if (to_machine) begin
               mstatus_in[teig_pkg::MPIE_BIT]     = mstatus_ff[teig_pkg::MIE_BIT];
               mstatus_in[teig_pkg::MIE_BIT]      = 1'b0;
               mstatus_in[teig_pkg::MPP_LSB +: 2] = level_ff;
               mepc_in   = req_data_ff.trap_pc;
               mcause_in = req_data_ff.cause;
               level_in  = teig_pkg::LEVEL_MACHINE;
               rsp_data_in.target_pc = machine_vector_ff;
            end else if (to_super) begin
               sstatus_in[teig_pkg::SPIE_BIT]     = sstatus_ff[teig_pkg::SIE_BIT];
               sstatus_in[teig_pkg::SIE_BIT]      = 1'b0;
               sstatus_in[teig_pkg::SPP_LSB +: 2] = level_ff;
               sepc_in   = req_data_ff.trap_pc;
               scause_in = req_data_ff.cause;
               mcause_in = req_data_ff.cause;
               level_in  = teig_pkg::LEVEL_SUPER;
               rsp_data_in.target_pc = supervisor_vector_ff;
            end else begin
               rsp_data_in.bad_level = 1'b1;
            end
         end
         teig_pkg::ACT_QUERY: begin
            // At machine level a taken interrupt is always reported as timer, whatever the serial input says.
            if ((level_ff == teig_pkg::LEVEL_MACHINE) && machine_irq_en_ff &&
                mstatus_ff[teig_pkg::MIE_BIT] && pending_ff) begin
               pending_in = 1'b0;
               rsp_data_in.irq_kind = teig_pkg::KIND_TIMER;
            end else if (low_level && supervisor_irq_en_ff &&
                         sstatus_ff[teig_pkg::SIE_BIT] && pending_ff) begin
               pending_in = 1'b0;
               rsp_data_in.irq_kind = req_data_ff.uart_ready ? teig_pkg::KIND_UART
                                                             : teig_pkg::KIND_TIMER;
            end
         end
         teig_pkg::ACT_POST: begin
            pending_in = 1'b1;
         end
         teig_pkg::ACT_RESTORE: begin
            mstatus_in = req_data_ff.new_mstatus;
            sstatus_in = req_data_ff.new_sstatus;
            level_in   = req_data_ff.new_level;
         end
         default: ;
      endcase

      rsp_data_in.mstatus = mstatus_in;
      rsp_data_in.sstatus = sstatus_in;
      rsp_data_in.mepc    = mepc_in;
      rsp_data_in.sepc    = sepc_in;
      rsp_data_in.mcause  = mcause_in;
      rsp_data_in.scause  = scause_in;
      rsp_data_in.level   = level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstatus_ff <= '0;
         sstatus_ff <= '0;
         mepc_ff    <= '0;
         sepc_ff    <= '0;
         mcause_ff  <= '0;
         scause_ff  <= '0;
         level_ff   <= teig_pkg::LEVEL_MACHINE;
         pending_ff <= 1'b0;
      end else if (advance) begin
         mstatus_ff <= mstatus_in;
         sstatus_ff <= sstatus_in;
         mepc_ff    <= mepc_in;
         sepc_ff    <= sepc_in;
         mcause_ff  <= mcause_in;
         scause_ff  <= scause_in;
         level_ff   <= level_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target_pc   = rsp_data_ff.target_pc;
   assign rsp_irq_kind    = rsp_data_ff.irq_kind;
   assign rsp_bad_level   = rsp_data_ff.bad_level;
   assign rsp_out_mstatus = rsp_data_ff.mstatus;
   assign rsp_out_sstatus = rsp_data_ff.sstatus;
   assign rsp_out_mepc    = rsp_data_ff.mepc;
   assign rsp_out_sepc    = rsp_data_ff.sepc;
   assign rsp_out_mcause  = rsp_data_ff.mcause;
   assign rsp_out_scause  = rsp_data_ff.scause;
   assign rsp_out_level   = rsp_data_ff.level;

endmodule
